// ===== rtl/m3i_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies; used by every module of the block.
package m3i_pkg;

  // Fraction bits added to a cofactor before dividing: the cofactor has 24, the
  // determinant 36 and the result 16.
  localparam int QSHIFT = 28;

  // Restoring-division steps done in one divider pipeline stage.
  localparam int DIV_STEPS = 4;

  typedef logic [3:0] idx_t;

  // Cofactor i is m[a]*m[b] - m[c]*m[d] with {a, b, c, d} = COF_IDX[i].
  localparam idx_t COF_IDX [9][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // Status of one divided entry.
  typedef struct packed {
    logic sat;   // entry was clipped
    logic zero;  // determinant was zero
  } div_flags_t;

endpackage

// ===== rtl/m3i_cofactor.sv =====
// Cofactor and determinant pipeline of the 3x3 matrix inverse (five stages).
// Depends on m3i_pkg.
module m3i_cofactor #(
  parameter int IN_W = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [IN_W-1:0]     m_i   [9],
  output logic signed [2*IN_W:0]     cof_o [9],
  output logic signed [3*IN_W+2:0]   det_o
);

  localparam int CW = 2 * IN_W + 1;
  localparam int PW = 3 * IN_W + 1;
  localparam int DW = 3 * IN_W + 3;

  logic signed [IN_W-1:0]  m_r    [9];
  logic signed [2*IN_W-1:0] p_r   [18];
  logic signed [IN_W-1:0]  m2_r   [3];
  logic signed [CW-1:0]    cof3_r [9];
  logic signed [IN_W-1:0]  m3_r   [3];
  logic signed [PW-1:0]    dp_r   [3];
  logic signed [CW-1:0]    cof4_r [9];
  logic signed [DW-1:0]    det_r;
  logic signed [CW-1:0]    cof5_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_i;
      for (int i = 0; i < 9; i++) begin
        p_r[2*i]   <= m_r[m3i_pkg::COF_IDX[i][0]] * m_r[m3i_pkg::COF_IDX[i][1]];
        p_r[2*i+1] <= m_r[m3i_pkg::COF_IDX[i][2]] * m_r[m3i_pkg::COF_IDX[i][3]];
      end
      for (int j = 0; j < 3; j++) begin
        m2_r[j] <= m_r[j];
        m3_r[j] <= m2_r[j];
      end
      for (int i = 0; i < 9; i++) begin
        cof3_r[i] <= CW'(p_r[2*i]) - CW'(p_r[2*i+1]);
        cof4_r[i] <= cof3_r[i];
        cof5_r[i] <= cof4_r[i];
      end
      // Expansion along row 0 gives the same value as all six triple products.
      dp_r[0] <= m3_r[0] * cof3_r[0];
      dp_r[1] <= m3_r[1] * cof3_r[3];
      dp_r[2] <= m3_r[2] * cof3_r[6];
      det_r   <= DW'(dp_r[0]) + DW'(dp_r[1]) + DW'(dp_r[2]);
    end
  end

  assign cof_o = cof5_r;
  assign det_o = det_r;

endmodule

// ===== rtl/m3i_divider.sv =====
// Pipelined signed restoring divider: (cof << QSHIFT) / det, truncated toward zero
// and saturated to OUT_W bits. Depends on m3i_pkg.
module m3i_divider #(
  parameter int IN_W  = 16,
  parameter int OUT_W = 32
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [2*IN_W:0]    cof_i,
  input  logic signed [3*IN_W+2:0]  det_i,
  output logic [OUT_W-1:0]          q_o,
  output m3i_pkg::div_flags_t       flags_o
);

  localparam int CW   = 2 * IN_W + 1;
  localparam int DW   = 3 * IN_W + 3;
  localparam int NW   = CW + m3i_pkg::QSHIFT;
  localparam int TW   = NW - OUT_W;
  localparam int CMPW = (TW > DW) ? TW : DW;
  localparam int DS   = (OUT_W + m3i_pkg::DIV_STEPS - 1) / m3i_pkg::DIV_STEPS;

  // Magnitudes and result sign.
  logic [CW-1:0] n_a_r;
  logic [DW-1:0] d_a_r;
  logic          neg_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n_a_r   <= cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
      d_a_r   <= det_i[DW-1] ? DW'(-det_i) : DW'(det_i);
      neg_a_r <= cof_i[CW-1] ^ det_i[DW-1];
    end
  end

  // Overflow check: the quotient reaches 2^OUT_W exactly when the numerator's
  // bits above OUT_W are not below the divisor.
  logic [NW-1:0] num;
  logic [TW-1:0] num_top;
  logic          big;

  assign num     = {n_a_r, {m3i_pkg::QSHIFT{1'b0}}};
  assign num_top = num[NW-1:OUT_W];
  assign big     = CMPW'(num_top) >= CMPW'(d_a_r);

  logic [DW-1:0]    rem_r [DS+1];
  logic [OUT_W-1:0] q_r   [DS+1];
  logic [OUT_W-1:0] low_r [DS+1];
  logic [DW-1:0]    dd_r  [DS+1];
  logic             neg_r [DS+1];
  logic             big_r [DS+1];
  logic             dz_r  [DS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= big ? '0 : DW'(num_top);
      q_r[0]   <= '0;
      low_r[0] <= num[OUT_W-1:0];
      dd_r[0]  <= d_a_r;
      neg_r[0] <= neg_a_r;
      big_r[0] <= big;
      dz_r[0]  <= (d_a_r == '0);
    end
  end

  for (genvar s = 0; s < DS; s++) begin : g_stage
    logic [DW-1:0]    rem_nxt;
    logic [OUT_W-1:0] q_nxt;
    logic [OUT_W-1:0] low_nxt;
    logic [DW:0]      r2;

    always_comb begin
      rem_nxt = rem_r[s];
      q_nxt   = q_r[s];
      low_nxt = low_r[s];
      r2      = '0;
      for (int k = 0; k < m3i_pkg::DIV_STEPS; k++) begin
        if (s * m3i_pkg::DIV_STEPS + k < OUT_W) begin
          r2      = {rem_nxt, low_nxt[OUT_W-1]};
          low_nxt = low_nxt << 1;
          q_nxt   = q_nxt << 1;
          if (r2 >= {1'b0, dd_r[s]}) begin
            r2       = r2 - {1'b0, dd_r[s]};
            q_nxt[0] = 1'b1;
          end
          rem_nxt = r2[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= rem_nxt;
        q_r[s+1]   <= q_nxt;
        low_r[s+1] <= low_nxt;
        dd_r[s+1]  <= dd_r[s];
        neg_r[s+1] <= neg_r[s];
        big_r[s+1] <= big_r[s];
        dz_r[s+1]  <= dz_r[s];
      end
    end
  end

  // Saturate, restore the sign and force zero for a singular matrix.
  logic [OUT_W-1:0] lim;
  logic [OUT_W-1:0] qs;
  logic             sat;
  logic [OUT_W-1:0] q_out_r;
  m3i_pkg::div_flags_t flags_r;

  assign lim = neg_r[DS] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  assign sat = big_r[DS] || (q_r[DS] > lim);
  assign qs  = sat ? lim : q_r[DS];

  always_ff @(posedge clk) begin
    if (en) begin
      q_out_r       <= dz_r[DS] ? '0 : (neg_r[DS] ? -qs : qs);
      flags_r.sat   <= !dz_r[DS] && sat;
      flags_r.zero  <= dz_r[DS];
    end
  end

  assign q_o     = q_out_r;
  assign flags_o = flags_r;

endmodule

// ===== rtl/matrix3_inverse.sv =====
// Top level of the 3x3 fixed-point matrix inverse; instantiates m3i_cofactor and
// nine m3i_divider units. Depends on m3i_pkg.

// One matrix word of nine signed Q4.12 entries enters per clock, and one inverse
// word of nine saturated Q16.16 entries leaves per clock, with singular and
// saturated flags. The multiplier and adder stages of m3i_cofactor form the
// cofactors and the determinant, then each entry goes through its own restoring
// divider that resolves four quotient bits per stage. A zero determinant gives
// all-zero entries with singular set. The whole pipeline advances together; while
// a finished word is held by out_stall nothing moves and in_stall is raised, so
// no word is lost or repeated, and with out_stall low one word is accepted every
// cycle.
module matrix3_inverse #(
  parameter int IN_WIDTH  = 16,
  parameter int OUT_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [IN_WIDTH-1:0]  in_a00,
  input  logic signed [IN_WIDTH-1:0]  in_a01,
  input  logic signed [IN_WIDTH-1:0]  in_a02,
  input  logic signed [IN_WIDTH-1:0]  in_a10,
  input  logic signed [IN_WIDTH-1:0]  in_a11,
  input  logic signed [IN_WIDTH-1:0]  in_a12,
  input  logic signed [IN_WIDTH-1:0]  in_a20,
  input  logic signed [IN_WIDTH-1:0]  in_a21,
  input  logic signed [IN_WIDTH-1:0]  in_a22,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_WIDTH-1:0] out_b00,
  output logic signed [OUT_WIDTH-1:0] out_b01,
  output logic signed [OUT_WIDTH-1:0] out_b02,
  output logic signed [OUT_WIDTH-1:0] out_b10,
  output logic signed [OUT_WIDTH-1:0] out_b11,
  output logic signed [OUT_WIDTH-1:0] out_b12,
  output logic signed [OUT_WIDTH-1:0] out_b20,
  output logic signed [OUT_WIDTH-1:0] out_b21,
  output logic signed [OUT_WIDTH-1:0] out_b22,
  output logic                        out_singular,
  output logic                        out_saturated
);

  localparam int CW  = 2 * IN_WIDTH + 1;
  localparam int DW  = 3 * IN_WIDTH + 3;
  localparam int LAT = 5 + 3 +
                       (OUT_WIDTH + m3i_pkg::DIV_STEPS - 1) / m3i_pkg::DIV_STEPS;

  // The pipeline moves unless a finished word is waiting on a stalled consumer.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // Valid bits travel alongside the data stages.
  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[LAT-1];

  logic signed [IN_WIDTH-1:0] m   [9];
  logic signed [CW-1:0]       cof [9];
  logic signed [DW-1:0]       det;

  assign m[0] = in_a00;
  assign m[1] = in_a01;
  assign m[2] = in_a02;
  assign m[3] = in_a10;
  assign m[4] = in_a11;
  assign m[5] = in_a12;
  assign m[6] = in_a20;
  assign m[7] = in_a21;
  assign m[8] = in_a22;

  m3i_cofactor #(
    .IN_W (IN_WIDTH)
  ) u_cofactor (
    .clk   (clk),
    .en    (en),
    .m_i   (m),
    .cof_o (cof),
    .det_o (det)
  );

  // The adjugate is the transpose of the cofactor matrix, which the cofactor
  // table already accounts for: cofactor i lands on inverse entry i.
  logic [OUT_WIDTH-1:0] q     [9];
  m3i_pkg::div_flags_t  flags [9];
  logic [8:0]           sat_vec;

  for (genvar i = 0; i < 9; i++) begin : g_div
    m3i_divider #(
      .IN_W  (IN_WIDTH),
      .OUT_W (OUT_WIDTH)
    ) u_div (
      .clk     (clk),
      .en      (en),
      .cof_i   (cof[i]),
      .det_i   (det),
      .q_o     (q[i]),
      .flags_o (flags[i])
    );
    assign sat_vec[i] = flags[i].sat;
  end

  assign out_b00       = q[0];
  assign out_b01       = q[1];
  assign out_b02       = q[2];
  assign out_b10       = q[3];
  assign out_b11       = q[4];
  assign out_b12       = q[5];
  assign out_b20       = q[6];
  assign out_b21       = q[7];
  assign out_b22       = q[8];
  assign out_singular  = flags[0].zero;
  assign out_saturated = |sat_vec;

  // A singular matrix never reports saturation and gives zero entries (checked on b00 and b22).
  a_singular_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> !out_saturated && out_b00 == '0 && out_b22 == '0)
    else $error("singular word carries nonzero data or saturation");

  // All dividers see the same determinant, so they agree on the zero flag (checked on dividers 0, 4 and 8).
  a_zero_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> flags[4].zero == flags[0].zero && flags[8].zero == flags[0].zero)
    else $error("dividers disagree on singular determinant");

  // While the output is held, no valid bit moves through the pipeline.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(vld_r))
    else $error("pipeline moved while output was stalled");

endmodule

// ===== bench/tb_matrix3_inverse.sv =====
// Self-checking testbench for matrix3_inverse: directed matrices from a table, then random
// ones, each inverse word compared against a behavioral model of the adjugate division.
// Depends on rtl/matrix3_inverse.sv and rtl/m3i_pkg.sv.
module tb_matrix3_inverse;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = 16;
  localparam int OW = 32;
  localparam int QSH = 28;
  localparam int N_RANDOM = 630;
  localparam int WATCHDOG = 5000;

  typedef logic signed [IW-1:0] entry_t;
  typedef logic signed [OW-1:0] inv_t;

  // One expected inverse word: nine entries plus the two flags.
  typedef struct {
    inv_t b [9];
    logic singular;
    logic saturated;
  } inverse_t;

  // A directed row: the matrix, and whether a typed-in answer is given.
  typedef struct {
    entry_t a [9];
    logic has_answer;
    inverse_t answer;
  } matrix_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  entry_t in_a [9];
  logic out_valid;
  logic out_stall = 1'b0;
  inv_t out_b [9];
  logic out_singular;
  logic out_saturated;

  inverse_t pending_inverses [$];
  int errors = 0;
  int accepted_in = 0;
  int accepted_out = 0;
  int n_singular = 0;
  int n_saturated = 0;
  int idle_cycles = 0;
  bit quiet_phase = 1'b0;
  bit hold_off_done = 1'b0;
  bit stim_done = 1'b0;

  always #6 clk = ~clk;

  initial begin
    foreach (in_a[i]) in_a[i] = '0;
  end

  matrix3_inverse #(.IN_WIDTH(IW), .OUT_WIDTH(OW)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a00(in_a[0]), .in_a01(in_a[1]), .in_a02(in_a[2]),
    .in_a10(in_a[3]), .in_a11(in_a[4]), .in_a12(in_a[5]),
    .in_a20(in_a[6]), .in_a21(in_a[7]), .in_a22(in_a[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_b00(out_b[0]), .out_b01(out_b[1]), .out_b02(out_b[2]),
    .out_b10(out_b[3]), .out_b11(out_b[4]), .out_b12(out_b[5]),
    .out_b20(out_b[6]), .out_b21(out_b[7]), .out_b22(out_b[8]),
    .out_singular(out_singular), .out_saturated(out_saturated)
  );

  // Divide one cofactor, scaled up by QSH bits, by the determinant. Truncation is
  // toward zero, and the quotient is clipped to the signed OW-bit range. The widest
  // scaled cofactor fits well under 128 bits, so plain wide division is exact.
  function automatic inv_t divide_entry(longint cof, longint det, ref logic sat);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quo;
    logic [127:0] lim;
    logic neg;
    num = (cof < 0) ? 128'(-cof) : 128'(cof);
    den = (det < 0) ? 128'(-det) : 128'(det);
    neg = (cof < 0) != (det < 0);
    quo = (num << QSH) / den;
    lim = neg ? (128'd1 << (OW - 1)) : ((128'd1 << (OW - 1)) - 1);
    if (quo > lim) begin
      sat = 1'b1;
      quo = lim;
    end
    if (neg) quo = -quo;
    return inv_t'(quo[OW-1:0]);
  endfunction

  // Exact determinant by the rule of Sarrus, then the adjugate divided through.
  function automatic inverse_t invert_matrix(entry_t a [9]);
    longint m [9];
    longint cof [9];
    longint det;
    inverse_t r;
    logic sat;
    foreach (m[i]) m[i] = longint'(a[i]);
    det = m[0]*m[4]*m[8] + m[1]*m[5]*m[6] + m[2]*m[3]*m[7]
        - m[2]*m[4]*m[6] - m[1]*m[3]*m[8] - m[5]*m[7]*m[0];
    cof[0] = m[4]*m[8] - m[5]*m[7];
    cof[1] = m[2]*m[7] - m[1]*m[8];
    cof[2] = m[1]*m[5] - m[2]*m[4];
    cof[3] = m[5]*m[6] - m[3]*m[8];
    cof[4] = m[0]*m[8] - m[2]*m[6];
    cof[5] = m[2]*m[3] - m[0]*m[5];
    cof[6] = m[3]*m[7] - m[4]*m[6];
    cof[7] = m[1]*m[6] - m[0]*m[7];
    cof[8] = m[0]*m[4] - m[1]*m[3];
    sat = 1'b0;
    if (det == 0) begin
      foreach (r.b[i]) r.b[i] = '0;
      r.singular = 1'b1;
      r.saturated = 1'b0;
      return r;
    end
    foreach (r.b[i]) r.b[i] = divide_entry(cof[i], det, sat);
    r.singular = 1'b0;
    r.saturated = sat;
    return r;
  endfunction

  // Directed table. Rows with a typed answer are ones readable at a glance: the
  // all-zero matrix and rank-deficient ones are singular with zero entries, and
  // identity scaled by one (4096 in Q4.12) inverts to one in Q16.16 (65536).
  matrix_row_t directed [$];

  function automatic matrix_row_t make_row(entry_t a [9]);
    matrix_row_t r;
    r.a = a;
    r.has_answer = 1'b0;
    r.answer = '{b: '{default: '0}, singular: 1'b0, saturated: 1'b0};
    return r;
  endfunction

  task automatic build_directed();
    matrix_row_t r;
    inverse_t zero_inv;
    inverse_t ident_inv;
    zero_inv = '{b: '{default: '0}, singular: 1'b1, saturated: 1'b0};
    ident_inv = '{b: '{default: '0}, singular: 1'b0, saturated: 1'b0};
    ident_inv.b[0] = 32'sd65536;
    ident_inv.b[4] = 32'sd65536;
    ident_inv.b[8] = 32'sd65536;
    // All zeros: singular.
    r = make_row('{default: '0});
    r.has_answer = 1'b1; r.answer = zero_inv; directed.push_back(r);
    // Identity.
    r = make_row('{16'sd4096, 0, 0, 0, 16'sd4096, 0, 0, 0, 16'sd4096});
    r.has_answer = 1'b1; r.answer = ident_inv; directed.push_back(r);
    // Every entry at the positive extreme: all rows equal, so singular.
    r = make_row('{default: 16'sh7fff});
    r.has_answer = 1'b1; r.answer = zero_inv; directed.push_back(r);
    // Every entry at the negative extreme: singular too.
    r = make_row('{default: 16'sh8000});
    r.has_answer = 1'b1; r.answer = zero_inv; directed.push_back(r);
    // Two equal rows with mixed content: singular.
    r = make_row('{16'sd100, -16'sd7, 16'sd3, 16'sd100, -16'sd7, 16'sd3, 16'sd5, 16'sd9, 16'sd1});
    r.has_answer = 1'b1; r.answer = zero_inv; directed.push_back(r);
    // Diagonal extremes and tiny diagonals, then a triangular matrix whose inverse clips.
    directed.push_back(make_row('{16'sh7fff, 0, 0, 0, 16'sh7fff, 0, 0, 0, 16'sh7fff}));
    directed.push_back(make_row('{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000}));
    directed.push_back(make_row('{16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1}));
    directed.push_back(make_row('{-16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, -16'sd1}));
    directed.push_back(make_row('{16'sd1, 16'sh7fff, 0, 0, 16'sd1, 16'sh8000, 0, 0, 16'sd1}));
    // Permutation and sign patterns, then general, banded and small-integer matrices.
    directed.push_back(make_row('{0, 16'sd4096, 0, 0, 0, 16'sd4096, 16'sd4096, 0, 0}));
    directed.push_back(make_row('{0, -16'sd4096, 0, 16'sd4096, 0, 0, 0, 0, -16'sd4096}));
    directed.push_back(make_row('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                                  16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000}));
    directed.push_back(make_row('{16'sh5555, 16'shaaaa, 16'sh1234, 16'shedcb, 16'sh0f0f,
                                  16'shf0f0, 16'sh3333, 16'shcccc, 16'sh7001}));
    directed.push_back(make_row('{16'sd8192, 16'sd4096, 0, 16'sd4096, 16'sd8192,
                                  16'sd4096, 0, 16'sd4096, 16'sd8192}));
    directed.push_back(make_row('{16'sd3, 16'sd5, 16'sd7, 16'sd2, 16'sd11, 16'sd13,
                                  16'sd17, 16'sd19, 16'sd23}));
  endtask

  // Random matrices: mostly full-range entries, some small entries giving tiny
  // determinants and clipping, some at the extremes, some made rank-deficient.
  function automatic void random_matrix(ref entry_t a [9]);
    int kind;
    int k;
    kind = $urandom_range(0, 9);
    foreach (a[i]) begin
      if (kind <= 5) a[i] = entry_t'($urandom);
      else if (kind <= 7) a[i] = entry_t'($signed($urandom_range(0, 64)) - 32);
      else a[i] = entry_t'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
    end
    if (kind == 9) begin
      k = $urandom_range(0, 2);
      // Copy one row over another, making the determinant zero.
      for (int c = 0; c < 3; c++) a[((k + 1) % 3) * 3 + c] = a[k * 3 + c];
    end
  endfunction

  int sender_gap = 0;

  // Offer one word and hold it until accepted. Random gaps come in bursts.
  task automatic send_matrix(entry_t a [9], inverse_t want);
    if (!quiet_phase && sender_gap == 0 && $urandom_range(0, 7) == 0)
      sender_gap = $urandom_range(1, 16);
    while (sender_gap > 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
      sender_gap--;
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) in_a[i] <= a[i];
    do @(posedge clk); while (in_stall);
    pending_inverses.push_back(want);
    accepted_in++;
  endtask

  initial begin
    entry_t a [9];
    inverse_t want;
    build_directed();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed table: a typed answer must agree with the model, then it is used.
    foreach (directed[r]) begin
      want = invert_matrix(directed[r].a);
      if (directed[r].has_answer && want != directed[r].answer) begin
        $error("directed row %0d: typed answer disagrees with prediction", r);
        errors++;
      end
      send_matrix(directed[r].a, directed[r].has_answer ? directed[r].answer : want);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 80) quiet_phase = 1'b1;
      random_matrix(a);
      send_matrix(a, invert_matrix(a));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stall bursts, one long hold-off early on so the pipeline
  // fills and pushes back on the sender, and no stalling in the last part.
  initial begin
    int burst;
    int hold;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_off_done && accepted_in >= 60) begin
        hold_off_done = 1'b1;
        out_stall <= 1'b1;
        hold = 0;
        while (hold < 60) begin
          @(posedge clk);
          hold++;
        end
        out_stall <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted word field by field against the oldest prediction.
  always @(posedge clk) begin
    inverse_t want;
    if (rst_n && out_valid && !out_stall) begin
      accepted_out++;
      if (pending_inverses.size() == 0) begin
        $error("inverse word with no matrix outstanding");
        errors++;
      end else begin
        want = pending_inverses.pop_front();
        if (want.singular) n_singular++;
        if (want.saturated) n_saturated++;
        for (int i = 0; i < 9; i++)
          if (out_b[i] !== want.b[i]) begin
            $error("b%0d%0d: expected %0d, got %0d", i / 3, i % 3, want.b[i], out_b[i]);
            errors++;
          end
        if (out_singular !== want.singular) begin
          $error("singular: expected %0b, got %0b", want.singular, out_singular);
          errors++;
        end
        if (out_saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, out_saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG);
      $display("matrix3_inverse test failed");
      $finish;
    end
  end

  // Wrap-up: drain, give the pipeline its latency to show any stray word, report.
  initial begin
    wait (stim_done);
    wait (pending_inverses.size() == 0);
    repeat (40) @(posedge clk);
    $display("Covered %0d matrices in, %0d inverses out; %0d singular, %0d saturated.",
             accepted_in, accepted_out, n_singular, n_saturated);
    if (errors == 0) $display("matrix3_inverse test passed");
    else $display("matrix3_inverse test failed");
    $finish;
  end

endmodule
